/* rtl/u8sd_pkg.sv */
`timescale 1ns / 1ps

package u8sd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CP_W     = 21;
    localparam int unsigned LEN_W    = 3;
    localparam int unsigned TAKEN_W  = 2;
    localparam int unsigned REP_W    = 3;

    localparam logic [CP_W-1:0] REPL_CP    = 21'h00FFFD;
    localparam logic [CP_W-1:0] MAX_CP     = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LO    = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI    = 21'h00DFFF;
    localparam logic [CP_W-1:0] MIN_CP_2   = 21'h000080;
    localparam logic [CP_W-1:0] MIN_CP_3   = 21'h000800;
    localparam logic [CP_W-1:0] MIN_CP_4   = 21'h010000;

    localparam logic [BYTE_W-1:0] CONT_MASK = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_TAG  = 8'h80;
    localparam logic [BYTE_W-1:0] CONT_BITS = 8'h3F;

    localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
    localparam logic [LEN_W-1:0] LEN_TWO  = 3'd2;
    localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
    localparam logic [LEN_W-1:0] LEN_FOUR = 3'd4;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        LEAD_END,
        LEAD_ASCII,
        LEAD_TWO,
        LEAD_THREE,
        LEAD_FOUR,
        LEAD_BAD
    } t_lead;

    // One request to the back end: a run of replacements, then an optional
    // plain code point or end marker.
    typedef struct packed {
        logic [REP_W-1:0] rep_cnt;
        logic             has_tail;
        logic             tail_end;
        logic [CP_W-1:0]  tail_cp;
    } t_cmd;

    function automatic t_lead classify_lead(input logic [BYTE_W-1:0] b);
        t_lead cls;
        if (b == '0) begin
            cls = LEAD_END;
        end else if (b[7] == 1'b0) begin
            cls = LEAD_ASCII;
        end else if (b[7:5] == 3'b110) begin
            cls = LEAD_TWO;
        end else if (b[7:4] == 4'b1110) begin
            cls = LEAD_THREE;
        end else if (b[7:3] == 5'b11110) begin
            cls = LEAD_FOUR;
        end else begin
            cls = LEAD_BAD;
        end
        return cls;
    endfunction

endpackage

/* rtl/u8sd_byte_if.sv */
`timescale 1ns / 1ps

interface u8sd_byte_if
    import u8sd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink (input valid, input byte_in, output ready);
endinterface

/* rtl/u8sd_cmd_if.sv */
`timescale 1ns / 1ps

interface u8sd_cmd_if
    import u8sd_pkg::*;
();
    logic valid;
    logic ready;
    t_cmd cmd;

    modport source (output valid, output cmd, input ready);
    modport sink (input valid, input cmd, output ready);
endinterface

/* rtl/u8sd_cp_if.sv */
`timescale 1ns / 1ps

interface u8sd_cp_if
    import u8sd_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [CP_W-1:0] codepoint;
    logic            is_replacement;
    logic            is_end;
    logic            last;

    modport source (output valid, output codepoint, output is_replacement,
                    output is_end, output last, input ready);
    modport sink (input valid, input codepoint, input is_replacement,
                  input is_end, input last, output ready);
endinterface

/* rtl/u8sd_front.sv */
`timescale 1ns / 1ps

module u8sd_front
    import u8sd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    u8sd_byte_if.sink   i_byte,
    u8sd_cmd_if.source  o_cmd
);

    logic [LEN_W-1:0]   r_exp_len, n_exp_len;
    logic [TAKEN_W-1:0] r_taken, n_taken;
    logic [CP_W-1:0]    r_partial, n_partial;

    logic               pending;
    logic               is_cont;
    logic [CP_W-1:0]    cont_cp;
    logic [LEN_W-1:0]   taken_next;
    logic               seq_bad;
    t_lead              lead;
    t_cmd               cmd;
    logic               accept;

    assign accept  = i_byte.valid && i_byte.ready;
    assign pending = (r_exp_len >= LEN_TWO) && (r_exp_len <= LEN_FOUR) && (r_taken != '0);
    assign is_cont = ((i_byte.byte_in & CONT_MASK) == CONT_TAG);
    assign cont_cp = {r_partial[CP_W-7:0], i_byte.byte_in[5:0]};
    assign taken_next = {1'b0, r_taken} + LEN_W'(1);
    assign lead    = classify_lead(i_byte.byte_in);

    always_comb begin
        seq_bad = ((r_exp_len == LEN_TWO) && (cont_cp < MIN_CP_2))
            || ((r_exp_len == LEN_THREE) && (cont_cp < MIN_CP_3))
            || ((r_exp_len == LEN_FOUR) && (cont_cp < MIN_CP_4))
            || ((cont_cp >= SURR_LO) && (cont_cp <= SURR_HI))
            || (cont_cp > MAX_CP);
    end

    always_comb begin
        n_exp_len = r_exp_len;
        n_taken   = r_taken;
        n_partial = r_partial;
        cmd       = '0;
        if (!pending || !is_cont) begin
            // A broken sequence replaces every byte taken, then the byte
            // starts over as a lead.
            cmd.rep_cnt = pending ? REP_W'(r_taken) : '0;
            n_exp_len = LEN_NONE;
            n_taken   = '0;
            n_partial = '0;
            unique case (lead)
                LEAD_END: begin
                    cmd.has_tail = 1'b1;
                    cmd.tail_end = 1'b1;
                end
                LEAD_ASCII: begin
                    cmd.has_tail = 1'b1;
                    cmd.tail_cp  = CP_W'(i_byte.byte_in);
                end
                LEAD_TWO: begin
                    n_exp_len = LEN_TWO;
                    n_taken   = TAKEN_W'(1);
                    n_partial = CP_W'(i_byte.byte_in[4:0]);
                end
                LEAD_THREE: begin
                    n_exp_len = LEN_THREE;
                    n_taken   = TAKEN_W'(1);
                    n_partial = CP_W'(i_byte.byte_in[3:0]);
                end
                LEAD_FOUR: begin
                    n_exp_len = LEN_FOUR;
                    n_taken   = TAKEN_W'(1);
                    n_partial = CP_W'(i_byte.byte_in[2:0]);
                end
                default: begin
                    cmd.rep_cnt = cmd.rep_cnt + REP_W'(1);
                end
            endcase
        end else if (taken_next < r_exp_len) begin
            n_partial = cont_cp;
            n_taken   = TAKEN_W'(taken_next);
        end else begin
            n_exp_len = LEN_NONE;
            n_taken   = '0;
            n_partial = '0;
            if (seq_bad) begin
                cmd.rep_cnt = REP_W'(r_exp_len);
            end else begin
                cmd.has_tail = 1'b1;
                cmd.tail_cp  = cont_cp;
            end
        end
    end

    assign i_byte.ready = o_cmd.ready;
    assign o_cmd.valid  = i_byte.valid && ((cmd.rep_cnt != '0) || cmd.has_tail);
    assign o_cmd.cmd    = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_len <= LEN_NONE;
            r_taken   <= '0;
            r_partial <= '0;
        end else if (accept) begin
            r_exp_len <= n_exp_len;
            r_taken   <= n_taken;
            r_partial <= n_partial;
        end
    end

endmodule

/* rtl/u8sd_queue.sv */
`timescale 1ns / 1ps

module u8sd_queue
    import u8sd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    u8sd_cmd_if.sink    i_push,
    u8sd_cmd_if.source  o_pop
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;
    logic              push;
    logic              pop;

    assign i_push.ready = (r_cnt != QCNT_W'(QUEUE_DEPTH));
    assign o_pop.valid  = (r_cnt != '0);
    assign o_pop.cmd    = r_mem[r_rp];
    assign push = i_push.valid && i_push.ready;
    assign pop  = o_pop.valid && o_pop.ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + QPTR_W'(1);
            end
            if (pop) begin
                r_rp <= (r_rp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + QPTR_W'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

endmodule

/* rtl/u8sd_back.sv */
`timescale 1ns / 1ps

module u8sd_back
    import u8sd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    u8sd_cmd_if.sink    i_cmd,
    u8sd_cp_if.source   o_cp
);

    logic [REP_W-1:0] r_idx;
    logic             r_valid;
    logic [CP_W-1:0]  r_cp;
    logic             r_rep;
    logic             r_end;
    logic             r_last;

    logic             load;
    logic             emit_rep;
    logic             emit_last;
    logic [REP_W-1:0] idx_inc;

    assign load     = i_cmd.valid && (!r_valid || o_cp.ready);
    assign emit_rep = (r_idx < i_cmd.cmd.rep_cnt);
    assign idx_inc  = r_idx + REP_W'(1);

    always_comb begin
        if (emit_rep) begin
            emit_last = (idx_inc == i_cmd.cmd.rep_cnt) && !i_cmd.cmd.has_tail;
        end else begin
            emit_last = 1'b1;
        end
    end

    assign i_cmd.ready = load && emit_last;

    assign o_cp.valid          = r_valid;
    assign o_cp.codepoint      = r_cp;
    assign o_cp.is_replacement = r_rep;
    assign o_cp.is_end         = r_end;
    assign o_cp.last           = r_last;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cp   <= emit_rep ? REPL_CP : i_cmd.cmd.tail_cp;
            r_rep  <= emit_rep;
            r_end  <= !emit_rep && i_cmd.cmd.tail_end;
            r_last <= emit_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= emit_last ? '0 : idx_inc;
            end else if (o_cp.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

/* rtl/utf8_stream_decoder.sv */
`timescale 1ns / 1ps

// Channel   Direction  Payload                                       Request
// i_byte    in         byte_in[7:0]                                  one raw byte
// o_cp      out        codepoint[20:0], is_replacement, is_end, last one result
//
// A byte is taken every cycle while the two-entry queue has room; results leave
// one per cycle from the output register while o_cp is ready, so a byte with
// more than one result holds the back end for each, and runs of replacements
// briefly fill the queue and stall i_byte. A byte is decoded and queued at the
// edge that takes it; its first result enters the output register when free.
// Reset is synchronous and active low, clears the pending sequence, the queue
// and the output valid.

module utf8_stream_decoder
    import u8sd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    u8sd_byte_if.sink   i_byte,
    u8sd_cp_if.source   o_cp
);

    u8sd_cmd_if front_cmd ();
    u8sd_cmd_if back_cmd ();

    u8sd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_byte),
        .o_cmd   (front_cmd.source)
    );

    u8sd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_cmd.sink),
        .o_pop   (back_cmd.source)
    );

    u8sd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (back_cmd.sink),
        .o_cp    (o_cp)
    );

endmodule
